@@ hw/rtl/fccm_pkg.sv @@
`timescale 1ns / 1ps

package fccm_pkg;

  localparam int MAX_TAPS    = 32;
  localparam int SAMPLE_BITS = 16;

  localparam int RES_BITS  = 40;
  localparam int TAP_IDX_W = 5;
  localparam int SEEN_W    = 6;
  localparam int SEEN_MAX  = 63;
  localparam int REG_IDX_W = 2;
  localparam int CFG_W     = 6;
  localparam int MODE_W    = 2;
  localparam int KLEN_CFG_W = 6;

  localparam int KIDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int KLEN_W = $clog2(MAX_TAPS + 1);
  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int ACC_RAW_W = PROD_W + KIDX_W + 1;
  localparam int ACC_W = (ACC_RAW_W > RES_BITS) ? ACC_RAW_W : RES_BITS;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_CONV_MODE     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_OPERATION     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_LENGTH = 2'd2;

  // conv_mode codes, bit 1 set means valid extent
  localparam logic [MODE_W-1:0] MODE_FULL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SAME = 2'd1;
  localparam int MODE_VALID_BIT = 1;

  localparam logic OP_CONV = 1'b0;
  localparam logic OP_CORR = 1'b1;

  localparam logic CMD_TAP    = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic              tap_we;
    logic              shift_en;
    logic              hist_clr;
    logic              rd_en;
    logic              rd_first;
    logic              rd_last;
    logic [KIDX_W-1:0] hidx;
    logic [KIDX_W-1:0] kidx;
  } dp_cmd_t;

  typedef struct packed {
    logic sum_done;
  } dp_status_t;

endpackage

@@ hw/rtl/fccm_dp.sv @@
`timescale 1ns / 1ps

module fccm_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  fccm_pkg::dp_cmd_t                    cmd_i,
  input  logic [fccm_pkg::TAP_IDX_W-1:0]       tap_index_i,
  input  logic signed [fccm_pkg::SAMPLE_BITS-1:0] data_value_i,
  output fccm_pkg::dp_status_t                 status_o,
  output logic signed [fccm_pkg::RES_BITS-1:0] result_value_o
);

  localparam int RES_BITS_LO = fccm_pkg::RES_BITS - 1;

  logic signed [fccm_pkg::SAMPLE_BITS-1:0] kernel_mem [fccm_pkg::MAX_TAPS];
  logic signed [fccm_pkg::SAMPLE_BITS-1:0] hist_q [fccm_pkg::MAX_TAPS];

  logic signed [fccm_pkg::SAMPLE_BITS-1:0] tap_q, samp_q;
  logic signed [fccm_pkg::PROD_W-1:0]      prod_q;
  logic signed [fccm_pkg::ACC_W-1:0]       acc_q, acc_d;
  logic b_vld_q, b_first_q, b_last_q;
  logic c_vld_q, c_first_q, c_last_q;
  logic done_q;
  logic [fccm_pkg::ACC_W-RES_BITS_LO-1:0] top_bits;

  // kernel store, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.tap_we) begin
      kernel_mem[fccm_pkg::KIDX_W'(tap_index_i)] <= data_value_i;
    end
    tap_q <= kernel_mem[cmd_i.kidx];
  end

  // delay line, entry 0 is the newest sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fccm_pkg::MAX_TAPS; i++) hist_q[i] <= '0;
    end else if (cmd_i.hist_clr) begin
      for (int i = 0; i < fccm_pkg::MAX_TAPS; i++) hist_q[i] <= '0;
    end else if (cmd_i.shift_en) begin
      for (int i = fccm_pkg::MAX_TAPS - 1; i > 0; i--) hist_q[i] <= hist_q[i-1];
      hist_q[0] <= data_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q <= hist_q[cmd_i.hidx];
    prod_q <= tap_q * samp_q;
    if (c_vld_q) begin
      acc_q <= acc_d;
    end
  end

  always_comb begin
    acc_d = c_first_q ? fccm_pkg::ACC_W'(prod_q) : acc_q + fccm_pkg::ACC_W'(prod_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q   <= 1'b0;
      b_first_q <= 1'b0;
      b_last_q  <= 1'b0;
      c_vld_q   <= 1'b0;
      c_first_q <= 1'b0;
      c_last_q  <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      b_vld_q   <= cmd_i.rd_en;
      b_first_q <= cmd_i.rd_first;
      b_last_q  <= cmd_i.rd_last;
      c_vld_q   <= b_vld_q;
      c_first_q <= b_first_q;
      c_last_q  <= b_last_q;
      done_q    <= c_vld_q && c_last_q;
    end
  end

  assign status_o.sum_done = done_q;

  // saturate to the result width
  assign top_bits = acc_q[fccm_pkg::ACC_W-1:RES_BITS_LO];
  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      result_value_o = acc_q[fccm_pkg::RES_BITS-1:0];
    end else begin
      result_value_o = {acc_q[fccm_pkg::ACC_W-1], {RES_BITS_LO{~acc_q[fccm_pkg::ACC_W-1]}}};
    end
  end

endmodule

@@ hw/rtl/fccm_ctrl.sv @@
`timescale 1ns / 1ps

module fccm_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               cmd_i,
  input  logic [fccm_pkg::TAP_IDX_W-1:0]     tap_index_i,
  input  logic                               end_of_block_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               last_result_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [fccm_pkg::REG_IDX_W-1:0]     cfg_index_i,
  input  logic [fccm_pkg::CFG_W-1:0]         cfg_data_i,
  output fccm_pkg::dp_cmd_t                  cmd_o,
  input  fccm_pkg::dp_status_t               status_i
);

  fccm_pkg::ctrl_state_e state_q, state_d;

  logic [fccm_pkg::MODE_W-1:0]     conv_mode_q;
  logic                            operation_q;
  logic [fccm_pkg::KLEN_CFG_W-1:0] kernel_length_q;

  logic [fccm_pkg::KIDX_W-1:0] k_q, k_d, t_q, t_d, t_end_q, t_end_d;
  logic [fccm_pkg::SEEN_W-1:0] seen_q, seen_d;
  logic                        eob_q, eob_d;

  logic [fccm_pkg::KLEN_W-1:0] klen, klen_m1, half, kidx_full;
  logic [fccm_pkg::KIDX_W-1:0] last_t, t_start;
  logic valid_mode, same_mode, emit_any, pos_ge_half;
  logic in_acc, out_acc, k_at_end, t_at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_mode_q     <= fccm_pkg::MODE_FULL;
      operation_q     <= fccm_pkg::OP_CONV;
      kernel_length_q <= fccm_pkg::KLEN_CFG_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fccm_pkg::REG_CONV_MODE:     conv_mode_q     <= cfg_data_i[fccm_pkg::MODE_W-1:0];
        fccm_pkg::REG_OPERATION:     operation_q     <= cfg_data_i[0];
        fccm_pkg::REG_KERNEL_LENGTH: kernel_length_q <= cfg_data_i[fccm_pkg::KLEN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // taps in use: zero acts as one, too large clamps
  always_comb begin
    if (kernel_length_q == '0) begin
      klen = fccm_pkg::KLEN_W'(1);
    end else if (int'(kernel_length_q) > fccm_pkg::MAX_TAPS) begin
      klen = fccm_pkg::KLEN_W'(fccm_pkg::MAX_TAPS);
    end else begin
      klen = fccm_pkg::KLEN_W'(kernel_length_q);
    end
  end

  assign klen_m1    = klen - fccm_pkg::KLEN_W'(1);
  assign half       = klen_m1 >> 1;
  assign valid_mode = conv_mode_q[fccm_pkg::MODE_VALID_BIT];
  assign same_mode  = !valid_mode && (conv_mode_q == fccm_pkg::MODE_SAME);
  assign pos_ge_half = int'(seen_q) >= int'(half);

  always_comb begin
    if (valid_mode) begin
      emit_any = int'(seen_q) >= int'(klen_m1);
      last_t   = '0;
    end else if (same_mode) begin
      emit_any = end_of_block_i || pos_ge_half;
      last_t   = fccm_pkg::KIDX_W'(half);
    end else begin
      emit_any = 1'b1;
      last_t   = fccm_pkg::KIDX_W'(klen_m1);
    end
    // same mode, block shorter than the lead-in: first tail offset
    if (same_mode && !pos_ge_half) begin
      t_start = fccm_pkg::KIDX_W'(half - fccm_pkg::KLEN_W'(seen_q));
    end else begin
      t_start = '0;
    end
  end

  assign kidx_full = (operation_q == fccm_pkg::OP_CORR) ?
                     klen_m1 - fccm_pkg::KLEN_W'(k_q) : fccm_pkg::KLEN_W'(k_q);
  assign k_at_end  = fccm_pkg::KLEN_W'(k_q) == klen_m1;
  assign t_at_end  = t_q == t_end_q;

  assign in_ready_o    = state_q == fccm_pkg::ST_IDLE;
  assign out_valid_o   = state_q == fccm_pkg::ST_OUT;
  assign last_result_o = eob_q && t_at_end;
  assign in_acc        = in_valid_i && in_ready_o;
  assign out_acc       = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fccm_pkg::ST_IDLE;
      k_q     <= '0;
      t_q     <= '0;
      t_end_q <= '0;
      seen_q  <= '0;
      eob_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      t_q     <= t_d;
      t_end_q <= t_end_d;
      seen_q  <= seen_d;
      eob_q   <= eob_d;
    end
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    t_d     = t_q;
    t_end_d = t_end_q;
    seen_d  = seen_q;
    eob_d   = eob_q;
    cmd_o          = '0;
    cmd_o.hidx     = k_q - t_q;
    cmd_o.kidx     = fccm_pkg::KIDX_W'(kidx_full);
    cmd_o.rd_first = k_q == t_q;
    cmd_o.rd_last  = k_at_end;

    case (state_q)
      fccm_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (cmd_i == fccm_pkg::CMD_TAP) begin
            cmd_o.tap_we = int'(tap_index_i) < fccm_pkg::MAX_TAPS;
          end else begin
            cmd_o.shift_en = 1'b1;
            if (int'(seen_q) < fccm_pkg::SEEN_MAX) begin
              seen_d = seen_q + fccm_pkg::SEEN_W'(1);
            end
            eob_d   = end_of_block_i;
            t_end_d = end_of_block_i ? last_t : '0;
            t_d     = t_start;
            k_d     = t_start;
            if (emit_any) begin
              state_d = fccm_pkg::ST_ISSUE;
            end else if (end_of_block_i) begin
              cmd_o.hist_clr = 1'b1;
              seen_d         = '0;
            end
          end
        end
      end
      fccm_pkg::ST_ISSUE: begin
        cmd_o.rd_en = 1'b1;
        if (k_at_end) begin
          state_d = fccm_pkg::ST_WAIT;
        end else begin
          k_d = k_q + fccm_pkg::KIDX_W'(1);
        end
      end
      fccm_pkg::ST_WAIT: begin
        if (status_i.sum_done) begin
          state_d = fccm_pkg::ST_OUT;
        end
      end
      fccm_pkg::ST_OUT: begin
        if (out_acc) begin
          if (t_at_end) begin
            if (eob_q) begin
              cmd_o.hist_clr = 1'b1;
              seen_d         = '0;
            end
            state_d = fccm_pkg::ST_IDLE;
          end else begin
            t_d     = t_q + fccm_pkg::KIDX_W'(1);
            k_d     = t_q + fccm_pkg::KIDX_W'(1);
            state_d = fccm_pkg::ST_ISSUE;
          end
        end
      end
      default: begin
        state_d = fccm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/fir_convolution_correlation_modes.sv @@
`timescale 1ns / 1ps
// tap write: no result
// each result at offset t issues the taps from t to K - 1 on the single shared multiplier, then
// goes through multiply, accumulate and hand-off before it is shown; one transaction in flight
// in full and same modes a sample that ends a block also emits its tail, one summation per result
// reset clears control, the delay line, the sample count and the registers
// (full, convolution, one tap); kernel taps hold no defined value until written

module fir_convolution_correlation_modes (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic                                    cmd_i,
  input  logic [fccm_pkg::TAP_IDX_W-1:0]          tap_index_i,
  input  logic signed [fccm_pkg::SAMPLE_BITS-1:0] data_value_i,
  input  logic                                    end_of_block_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [fccm_pkg::RES_BITS-1:0]    result_value_o,
  output logic                                    last_result_o,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [fccm_pkg::REG_IDX_W-1:0]          cfg_index_i,
  input  logic [fccm_pkg::CFG_W-1:0]              cfg_data_i
);

  fccm_pkg::dp_cmd_t    dp_cmd;
  fccm_pkg::dp_status_t dp_status;

  fccm_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .tap_index_i    (tap_index_i),
    .end_of_block_i (end_of_block_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .last_result_o  (last_result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_o          (dp_cmd),
    .status_i       (dp_status)
  );

  fccm_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .tap_index_i    (tap_index_i),
    .data_value_i   (data_value_i),
    .status_o       (dp_status),
    .result_value_o (result_value_o)
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import fccm_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned ITEM_TARGET  = 260;
  localparam int unsigned QUIET_AFTER  = 215;

  localparam logic [REG_IDX_W-1:0] REG_SPARE      = 2'd3;
  localparam logic [MODE_W-1:0]    MODE_VALID     = 2'd2;
  localparam logic [MODE_W-1:0]    MODE_VALID_ALT = 2'd3;

  typedef struct packed {
    logic signed [RES_BITS-1:0] value;
    logic                       last;
  } fir_result_t;

  typedef enum logic {
    ROW_CONFIG,
    ROW_ITEM
  } row_kind_e;

  typedef struct packed {
    row_kind_e                     kind;
    logic                          cmd;
    logic [TAP_IDX_W-1:0]          idx;
    logic signed [SAMPLE_BITS-1:0] data;
    logic                          eob;
    logic [MODE_W-1:0]             mode;
    logic                          op;
    logic [CFG_W-1:0]              klen;
    logic                          fixed;
    logic                          fixed_none;
    longint                        fixed_value;
    logic                          fixed_last;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic                          cmd       = 1'b0;
  logic [TAP_IDX_W-1:0]          tap_index = '0;
  logic signed [SAMPLE_BITS-1:0] data_value = '0;
  logic                          end_of_block = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [RES_BITS-1:0]    result_value;
  logic                          last_result;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [REG_IDX_W-1:0]          cfg_index = '0;
  logic [CFG_W-1:0]              cfg_data  = '0;

  // predictor state
  logic signed [SAMPLE_BITS-1:0] kernel     [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] delay_line [MAX_TAPS];
  int unsigned                   block_fill;
  logic [MODE_W-1:0]             mode_reg;
  logic                          op_reg;
  logic [CFG_W-1:0]              klen_reg;

  fir_result_t fresh_sums[$];
  fir_result_t pending_sums[$];
  stim_row_t   stim_rows[$];

  int unsigned items_sent  = 0;
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          quiet = 1'b0;
  bit          calm  = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  fir_convolution_correlation_modes i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .cmd_i         (cmd),
    .tap_index_i   (tap_index),
    .data_value_i  (data_value),
    .end_of_block_i(end_of_block),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .result_value_o(result_value),
    .last_result_o (last_result),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  function automatic logic signed [RES_BITS-1:0] fir_sum(int unsigned taps, int unsigned lag);
    longint                        acc;
    longint                        lim;
    logic signed [SAMPLE_BITS-1:0] coef;
    int unsigned                   k;
    acc = 0;
    lim = longint'(1) <<< (RES_BITS - 1);
    for (k = lag; k < taps; k++) begin
      // correlation walks the kernel backwards
      coef = (op_reg == OP_CORR) ? kernel[taps - 1 - k] : kernel[k];
      acc += longint'(coef) * longint'(delay_line[k - lag]);
    end
    if (acc >= lim) acc = lim - 1;
    if (acc < -lim) acc = -lim;
    return acc[RES_BITS-1:0];
  endfunction

  function automatic void fir_step(logic c, logic [TAP_IDX_W-1:0] idx,
                                   logic signed [SAMPLE_BITS-1:0] d, logic eob);
    int unsigned taps, half, pos, k, t;
    bit          valid_m, same_m;
    fir_result_t tail;
    fresh_sums.delete();
    if (c == CMD_TAP) begin
      kernel[idx] = d;
      return;
    end
    taps = (klen_reg == 0) ? 1 : (klen_reg > MAX_TAPS) ? MAX_TAPS : klen_reg;
    half = (taps - 1) / 2;
    valid_m = mode_reg[MODE_VALID_BIT];
    same_m  = !valid_m && (mode_reg == MODE_SAME);
    for (k = MAX_TAPS - 1; k > 0; k--) delay_line[k] = delay_line[k - 1];
    delay_line[0] = d;
    pos = block_fill;
    if (block_fill < SEEN_MAX) block_fill++;
    if ((valid_m && pos >= taps - 1) || (same_m && pos >= half) || (!valid_m && !same_m))
      fresh_sums.push_back('{fir_sum(taps, 0), 1'b0});
    if (!eob) return;
    // tail flush, older offsets only
    if (!valid_m) begin
      for (t = 1; t < taps; t++) begin
        if (!same_m || (t <= half && block_fill - 1 + t >= half))
          fresh_sums.push_back('{fir_sum(taps, t), 1'b0});
      end
    end
    if (fresh_sums.size() > 0) begin
      tail = fresh_sums.pop_back();
      tail.last = 1'b1;
      fresh_sums.push_back(tail);
    end
    foreach (delay_line[i]) delay_line[i] = '0;
    block_fill = 0;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
      1:       return {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic void add_cfg(logic [MODE_W-1:0] m, logic o, logic [CFG_W-1:0] kl);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CONFIG;
    r.mode = m;
    r.op   = o;
    r.klen = kl;
    stim_rows.push_back(r);
  endfunction

  function automatic void add_item(logic c, logic [TAP_IDX_W-1:0] idx,
                                   logic signed [SAMPLE_BITS-1:0] d, logic eob);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.cmd  = c;
    r.idx  = idx;
    r.data = d;
    r.eob  = eob;
    stim_rows.push_back(r);
  endfunction

  function automatic void add_checked(logic c, logic [TAP_IDX_W-1:0] idx,
                                      logic signed [SAMPLE_BITS-1:0] d, logic eob,
                                      logic none, longint value, logic last);
    stim_row_t r;
    add_item(c, idx, d, eob);
    r = stim_rows.pop_back();
    r.fixed       = 1'b1;
    r.fixed_none  = none;
    r.fixed_value = value;
    r.fixed_last  = last;
    stim_rows.push_back(r);
  endfunction

  task automatic offer_item(logic c, logic [TAP_IDX_W-1:0] idx,
                            logic signed [SAMPLE_BITS-1:0] d, logic eob);
    in_valid     <= 1'b1;
    cmd          <= c;
    tap_index    <= idx;
    data_value   <= d;
    end_of_block <= eob;
    do @(posedge clk_i); while (!in_ready);
    fir_step(c, idx, d, eob);
    items_sent++;
    if (items_sent >= QUIET_AFTER) quiet = 1'b1;
  endtask

  task automatic commit_sums();
    foreach (fresh_sums[i]) pending_sums.push_back(fresh_sums[i]);
  endtask

  task automatic idle_gap();
    if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic send_item(logic c, logic [TAP_IDX_W-1:0] idx,
                           logic signed [SAMPLE_BITS-1:0] d, logic eob);
    offer_item(c, idx, d, eob);
    commit_sums();
    idle_gap();
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      REG_CONV_MODE:     mode_reg = val[MODE_W-1:0];
      REG_OPERATION:     op_reg   = val[0];
      REG_KERNEL_LENGTH: klen_reg = val;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [MODE_W-1:0] m, logic o, logic [CFG_W-1:0] kl, bit poke);
    logic [CFG_W-1:0] junk;
    junk = CFG_W'($urandom);
    in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk_i);
    // a tap write or an empty valid block may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    // upper bits are junk, the block masks them
    write_reg(REG_CONV_MODE, {junk[CFG_W-1:MODE_W], m});
    write_reg(REG_OPERATION, {junk[CFG_W-1:1], o});
    write_reg(REG_KERNEL_LENGTH, kl);
    if (poke) write_reg(REG_SPARE, CFG_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin : ready_gen
    int unsigned hold;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (quiet) out_ready <= 1'b1;
      else if (hold > 0) hold--;
      else begin
        case ($urandom_range(0, 7))
          0, 1: begin
            out_ready <= 1'b0;
            hold = $urandom_range(0, 15);
          end
          2: begin
            out_ready <= 1'b1;
            hold = $urandom_range(40, 200);
          end
          default: begin
            out_ready <= 1'b1;
            hold = $urandom_range(0, 15);
          end
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    fir_result_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_sums.size() == 0) begin
        $error("result_value: no transaction expected, got %0d", result_value);
        mismatches++;
      end else begin
        want = pending_sums.pop_front();
        if (result_value !== want.value) begin
          $error("result_value: expected %0d, got %0d", $signed(want.value), result_value);
          mismatches++;
        end
        if (last_result !== want.last) begin
          $error("last_result: expected %0d, got %0d", want.last, last_result);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** fir_convolution_correlation_modes: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned      p, b, nblk, len, s;
    logic [MODE_W-1:0] m;
    logic             o;
    logic [CFG_W-1:0] kl;
    foreach (kernel[i]) kernel[i] = '0;
    foreach (delay_line[i]) delay_line[i] = '0;
    block_fill = 0;
    mode_reg   = MODE_FULL;
    op_reg     = OP_CONV;
    klen_reg   = 1;

    // reset settings: full, convolution, one tap
    add_item(CMD_TAP, 0, 16'sh7fff, 1'b0);
    add_checked(CMD_SAMPLE, '1, 16'sh7fff, 1'b0, 1'b0, 64'sd1073676289, 1'b0);
    add_checked(CMD_SAMPLE, '1, -16'sh8000, 1'b1, 1'b0, -64'sd1073709056, 1'b1);
    add_item(CMD_TAP, 0, -16'sh8000, 1'b0);
    add_checked(CMD_SAMPLE, '1, -16'sh8000, 1'b1, 1'b0, 64'sd1073741824, 1'b1);
    add_item(CMD_TAP, 1, 16'sd16384, 1'b0);
    // end flag on a tap write does nothing
    add_checked(CMD_TAP, 2, -16'sd1, 1'b1, 1'b1, 0, 1'b0);
    add_item(CMD_TAP, 31, 16'sd12345, 1'b0);
    add_cfg(MODE_FULL, OP_CONV, 3);
    add_item(CMD_SAMPLE, 0, 16'sd100, 1'b0);
    add_item(CMD_TAP, 1, 16'sd8192, 1'b0);
    add_item(CMD_SAMPLE, 0, -16'sd200, 1'b0);
    add_item(CMD_SAMPLE, 0, 16'sh7fff, 1'b1);
    add_cfg(MODE_SAME, OP_CONV, 3);
    add_item(CMD_SAMPLE, 0, 16'sd5, 1'b0);
    add_item(CMD_SAMPLE, 0, -16'sh8000, 1'b1);
    add_cfg(MODE_VALID, OP_CONV, 3);
    // block shorter than the kernel: nothing comes out
    add_checked(CMD_SAMPLE, 0, 16'sd1, 1'b1, 1'b1, 0, 1'b0);
    add_item(CMD_SAMPLE, 0, 16'sd11, 1'b0);
    add_item(CMD_SAMPLE, 0, -16'sd22, 1'b0);
    add_item(CMD_SAMPLE, 0, 16'sd33, 1'b0);
    add_item(CMD_SAMPLE, 0, -16'sh8000, 1'b1);
    add_cfg(MODE_VALID_ALT, OP_CORR, 3);
    add_item(CMD_SAMPLE, 0, 16'sd300, 1'b0);
    add_item(CMD_SAMPLE, 0, 16'sh7fff, 1'b0);
    add_item(CMD_SAMPLE, 0, -16'sd7, 1'b1);
    // zero length acts as one tap
    add_cfg(MODE_SAME, OP_CORR, 0);
    add_checked(CMD_SAMPLE, 0, -16'sh8000, 1'b1, 1'b0, 64'sd1073741824, 1'b1);
    add_item(CMD_SAMPLE, 0, 16'sd7, 1'b0);
    add_item(CMD_SAMPLE, 0, 16'sd9, 1'b1);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CONFIG) begin
        set_config(stim_rows[i].mode, stim_rows[i].op, stim_rows[i].klen, 1'b0);
      end else begin
        offer_item(stim_rows[i].cmd, stim_rows[i].idx, stim_rows[i].data, stim_rows[i].eob);
        if (stim_rows[i].fixed) begin
          fresh_sums.delete();
          if (!stim_rows[i].fixed_none)
            fresh_sums.push_back('{stim_rows[i].fixed_value[RES_BITS-1:0],
                                   stim_rows[i].fixed_last});
        end
        commit_sums();
        idle_gap();
      end
    end

    // full kernel so any length reads written taps only
    for (int i = 0; i < MAX_TAPS; i++)
      send_item(CMD_TAP, TAP_IDX_W'(i), rand_sample(), 1'($urandom_range(0, 1)));

    p = 0;
    while (items_sent < ITEM_TARGET) begin
      calm = ($urandom_range(0, 3) == 0);
      case (p)
        0: set_config(MODE_FULL, OP_CONV, CFG_W'(MAX_TAPS), 1'b1);
        1: set_config(MODE_VALID, OP_CORR, CFG_W'(MAX_TAPS), 1'b0);
        2: set_config(MODE_SAME, OP_CORR, CFG_W'(MAX_TAPS), 1'b0);
        3: set_config(MODE_VALID_ALT, OP_CONV, '1, 1'b0);
        4: set_config(MODE_SAME, OP_CONV, 5, 1'b0);
        default: begin
          m = MODE_W'($urandom_range(0, 3));
          o = 1'($urandom_range(0, 1));
          case ($urandom_range(0, 7))
            0:       kl = 1;
            1:       kl = CFG_W'(MAX_TAPS);
            2, 3:    kl = CFG_W'($urandom_range(2, 6));
            4, 5:    kl = CFG_W'($urandom_range(7, 31));
            6:       kl = 0;
            default: kl = CFG_W'($urandom_range(33, 63));
          endcase
          set_config(m, o, kl, $urandom_range(0, 3) == 0);
        end
      endcase
      nblk = $urandom_range(1, 3);
      for (b = 0; b < nblk; b++) begin
        // one block past the sample counter saturation point
        if (p == 4 && b == 0) len = 70;
        else if ($urandom_range(0, 9) == 0) len = $urandom_range(11, 40);
        else len = $urandom_range(1, 10);
        for (s = 0; s < len; s++) begin
          if ($urandom_range(0, 11) == 0)
            send_item(CMD_TAP, TAP_IDX_W'($urandom), rand_sample(), 1'($urandom_range(0, 1)));
          send_item(CMD_SAMPLE, TAP_IDX_W'($urandom), rand_sample(), s == len - 1);
        end
      end
      p++;
    end

    in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** fir_convolution_correlation_modes: PASSED **");
    end else begin
      $display("** fir_convolution_correlation_modes: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/fccm_pkg.sv
hw/rtl/fccm_dp.sv
hw/rtl/fccm_ctrl.sv
hw/rtl/fir_convolution_correlation_modes.sv
tb/tb_top.sv
